[sv/knn_majority_classifier_unit_defines.svh]
// ------------------------------------------------------------------------
// knn_majority_classifier_unit_defines: assertion macros.
// Used by knn_checker, the checker of the k-nearest-neighbor classifier.
// ------------------------------------------------------------------------
`ifndef KNN_MAJORITY_CLASSIFIER_UNIT_DEFINES_SVH
`define KNN_MAJORITY_CLASSIFIER_UNIT_DEFINES_SVH
// Implication that must hold at every clock edge outside reset.
`define KNN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define KNN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

[sv/knn_pkg.sv]
// ------------------------------------------------------------------------
// knn_pkg: shared types and constants of the k-nearest-neighbor classifier.
// Holds the sizes, opcode, register and status codes and the job and result words.
// ------------------------------------------------------------------------
package knn_pkg;

	// Store and list sizes.
	localparam int MAX_ENTRIES  = 1024;
	localparam int MAX_FEATURES = 32;
	localparam int MAX_K        = 15;
	localparam int NUM_CLASSES  = 8;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [1:0] REG_NEIGHBORS = 2'd0;
	localparam logic [1:0] REG_ENTRIES   = 2'd1;
	localparam logic [1:0] REG_FEATURES  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_CLAMPED = 2'd2;

	// One classification job, handed from the front end to the scan engine.
	typedef struct packed {
		logic [10:0] n_entries;
		logic [5:0]  n_feat;
		logic [5:0]  k;
		logic [1:0]  status;
	} job_t;

	// One result word.
	typedef struct packed {
		logic [2:0] cls;
		logic [3:0] votes;
		logic [1:0] status;
	} res_t;

endpackage

[sv/knn_majority_classifier_unit.sv]
// ------------------------------------------------------------------------
// knn_majority_classifier_unit: k-nearest-neighbor majority classifier.
// For a query word with last_feature set, the scan engine runs, for each
// entry in use, one multiply-accumulate per feature in use against the
// training memory, drains the pipeline, then places the entry by shifting
// the k-best list, and after the last entry votes over the k-best list
// and hands the result on. With no entries in use it skips the scan and
// the vote. Every input word waits while a query is queued or being scanned,
// because the scan reads the training and query stores; otherwise loads and
// query features are taken every cycle. One finished result waits in the
// output register and one more in the scan engine.
// ------------------------------------------------------------------------
module knn_majority_classifier_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [10:0] wr_data,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [9:0]  entry_index,
	input  logic [4:0]  feature_index,
	input  logic signed [15:0] feature_value,
	input  logic [2:0]  class_label,
	input  logic        last_feature,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  predicted_class,
	output logic [3:0]  winning_votes,
	output logic [1:0]  status
);
	knn_pkg::job_t job_in, jq_q [2];
	knn_pkg::res_t res;
	logic tr_we, q_we, job_push, job_pop, res_valid, back_busy;
	logic [1:0] jcnt_q;
	logic jrd_q, jwr_q;
	logic res_full_q;

	knn_front u_front (
		.clk, .arst_n, .wr_en, .wr_index, .wr_data, .push, .action, .entry_index,
		.feature_index, .last_feature, .job_full(jcnt_q != 2'd0 || back_busy), .full,
		.tr_we, .q_we, .job_push, .job(job_in));

	// Two-entry job queue between front and back; it never holds more than one job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jcnt_q <= '0; jrd_q <= 1'b0; jwr_q <= 1'b0;
			jq_q[0] <= '0; jq_q[1] <= '0;
		end else begin
			if (job_push) begin jq_q[jwr_q] <= job_in; jwr_q <= ~jwr_q; end
			if (job_pop) jrd_q <= ~jrd_q;
			jcnt_q <= jcnt_q + 2'(job_push) - 2'(job_pop);
		end
	end

	knn_back u_back (
		.clk, .arst_n, .job_valid(jcnt_q != 2'd0), .job(jq_q[jrd_q]), .job_pop,
		.busy(back_busy), .tr_we, .q_we, .entry_index, .feature_index, .feature_value,
		.class_label, .res_valid, .res, .res_take(!res_full_q));

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_full_q <= 1'b0;
			predicted_class <= '0; winning_votes <= '0; status <= '0;
		end else if (res_valid && !res_full_q) begin
			res_full_q <= 1'b1;
			predicted_class <= res.cls; winning_votes <= res.votes; status <= res.status;
		end else if (pop) res_full_q <= 1'b0;
	end
	assign empty = !res_full_q;
endmodule

[sv/knn_front.sv]
// ------------------------------------------------------------------------
// knn_front: input decode and configuration.
// Writes training and query stores, and turns a last query word into a job.
// ------------------------------------------------------------------------
module knn_front (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [10:0] wr_data,
	input  logic        push,
	input  logic        action,
	input  logic [9:0]  entry_index,
	input  logic [4:0]  feature_index,
	input  logic        last_feature,
	input  logic        job_full,
	output logic        full,
	output logic        tr_we,
	output logic        q_we,
	output logic        job_push,
	output knn_pkg::job_t job
);
	logic [3:0]  k_q;
	logic [10:0] ent_q;
	logic [5:0]  feat_q;
	logic        acc;
	logic [10:0] n;
	logic [5:0]  nf;
	logic [5:0]  k0;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= 4'd3;
			ent_q <= 11'd0;
			feat_q <= 6'd32;
		end else if (wr_en) begin
			case (wr_index)
				knn_pkg::REG_NEIGHBORS: k_q <= wr_data[3:0];
				knn_pkg::REG_ENTRIES: ent_q <= wr_data;
				knn_pkg::REG_FEATURES: feat_q <= wr_data[5:0];
				default: ;
			endcase
		end
	end

	// Every word waits while a job is queued or scanned, since the scan reads the stores.
	assign full = job_full;
	assign acc = push && !full;
	assign tr_we = acc && action == knn_pkg::ACT_LOAD
		&& 32'(entry_index) < knn_pkg::MAX_ENTRIES
		&& 32'(feature_index) < knn_pkg::MAX_FEATURES;
	assign q_we = acc && action == knn_pkg::ACT_QUERY
		&& 32'(feature_index) < knn_pkg::MAX_FEATURES;
	assign job_push = acc && action == knn_pkg::ACT_QUERY && last_feature;

	// Clamp counts for the job.
	always_comb begin
		n = (32'(ent_q) > knn_pkg::MAX_ENTRIES) ? 11'(knn_pkg::MAX_ENTRIES) : ent_q;
		nf = (32'(feat_q) > knn_pkg::MAX_FEATURES) ? 6'(knn_pkg::MAX_FEATURES) : feat_q;
		k0 = (k_q == 4'd0) ? 6'd1 : 6'(k_q);
		if (32'(k0) > knn_pkg::MAX_K) k0 = 6'(knn_pkg::MAX_K);
		job.n_entries = n;
		job.n_feat = nf;
		job.status = knn_pkg::ST_OK;
		job.k = k0;
		if (n == 11'd0) begin
			job.status = knn_pkg::ST_EMPTY;
		end else if (11'(k0) > n) begin
			job.k = 6'(n);
			job.status = knn_pkg::ST_CLAMPED;
		end
	end
endmodule

[sv/knn_back.sv]
// ------------------------------------------------------------------------
// knn_back: distance scan, k-best insertion and majority vote.
// One multiply-accumulate per cycle, then a serial insert and a vote pass.
// ------------------------------------------------------------------------
module knn_back (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	input  knn_pkg::job_t job,
	output logic        job_pop,
	output logic        busy,
	input  logic        tr_we,
	input  logic        q_we,
	input  logic [9:0]  entry_index,
	input  logic [4:0]  feature_index,
	input  logic signed [15:0] feature_value,
	input  logic [2:0]  class_label,
	output logic        res_valid,
	output knn_pkg::res_t res,
	input  logic        res_take
);
	localparam int EW = $clog2(knn_pkg::MAX_ENTRIES);
	localparam int FW = $clog2(knn_pkg::MAX_FEATURES);
	localparam int KW = $clog2(knn_pkg::MAX_K + 1);
	localparam int CW = $clog2(knn_pkg::NUM_CLASSES);
	localparam logic [2:0] S_IDLE = 3'd0, S_MAC = 3'd1, S_INS = 3'd2,
		S_VOTE = 3'd3, S_OUT = 3'd4;

	logic signed [15:0] tr_mem [knn_pkg::MAX_ENTRIES*knn_pkg::MAX_FEATURES];
	logic [2:0] lab_mem [knn_pkg::MAX_ENTRIES];
	logic signed [15:0] q_mem [knn_pkg::MAX_FEATURES];

	logic [2:0]  state_q;
	knn_pkg::job_t job_q;
	logic [EW:0] e_q;
	logic [FW:0] f_q;
	logic        rd_v_s1, rd_v_s2;
	logic signed [15:0] tr_s1, qv_s1;
	logic signed [16:0] diff_s2;
	logic [33:0] sq_s3;
	logic        sq_v_s3;
	logic [38:0] sum_q;
	logic [2:0]  lab_q;
	logic [38:0] bd_q [knn_pkg::MAX_K];
	logic [2:0]  bl_q [knn_pkg::MAX_K];
	logic [KW-1:0] filled_q, pos_q;
	logic [3:0]  tally_q [knn_pkg::NUM_CLASSES];
	logic [CW:0] c_q;
	logic [3:0]  votes_q;
	logic [2:0]  win_q;
	logic [FW:0] f_rd;
	logic        mac_done;
	logic [39:0] sum_n;
	logic [3:0]  best_cnt;
	logic [2:0]  best_cls;

	// Stores.
	always_ff @(posedge clk) begin
		if (tr_we) begin
			tr_mem[{entry_index[EW-1:0], feature_index[FW-1:0]}] <= feature_value;
			lab_mem[entry_index[EW-1:0]] <= (32'(class_label) < knn_pkg::NUM_CLASSES) ?
				class_label : 3'(knn_pkg::NUM_CLASSES - 1);
		end
		if (q_we) q_mem[feature_index[FW-1:0]] <= feature_value;
		tr_s1 <= tr_mem[{e_q[EW-1:0], f_q[FW-1:0]}];
		qv_s1 <= q_mem[f_q[FW-1:0]];
		lab_q <= lab_mem[e_q[EW-1:0]];
		diff_s2 <= 17'(qv_s1) - 17'(tr_s1);
		sq_s3 <= 34'(diff_s2 * diff_s2);
	end

	assign f_rd = f_q;
	assign mac_done = state_q == S_MAC && !rd_v_s1 && !rd_v_s2 && !sq_v_s3
		&& f_rd >= job_q.n_feat;
	assign sum_n = 40'(sum_q) + 40'(sq_s3);
	assign job_pop = state_q == S_IDLE && job_valid;
	assign busy = state_q == S_MAC || state_q == S_INS || state_q == S_VOTE;
	assign res_valid = state_q == S_OUT;
	assign res = '{cls: win_q, votes: votes_q, status: job_q.status};

	// Largest tally; only a strictly larger count displaces, so the lowest class wins ties.
	always_comb begin
		best_cnt = 4'd0;
		best_cls = 3'd0;
		for (int c = 0; c < knn_pkg::NUM_CLASSES; c++)
			if (tally_q[c] > best_cnt) begin
				best_cnt = tally_q[c];
				best_cls = 3'(c);
			end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rd_v_s1 <= 1'b0; rd_v_s2 <= 1'b0; sq_v_s3 <= 1'b0;
			job_q <= '0;
			e_q <= '0; f_q <= '0; sum_q <= '0;
			filled_q <= '0; pos_q <= '0; c_q <= '0;
			votes_q <= '0; win_q <= '0;
			for (int i = 0; i < knn_pkg::MAX_K; i++) begin
				bd_q[i] <= '1;
				bl_q[i] <= '0;
			end
			for (int c = 0; c < knn_pkg::NUM_CLASSES; c++) tally_q[c] <= 4'd0;
		end else begin
			rd_v_s1 <= state_q == S_MAC && f_q < job_q.n_feat;
			rd_v_s2 <= rd_v_s1;
			sq_v_s3 <= rd_v_s2;
			case (state_q)
				S_IDLE: if (job_valid) begin
					job_q <= job;
					e_q <= '0; f_q <= '0; sum_q <= '0; filled_q <= '0;
					for (int c = 0; c < knn_pkg::NUM_CLASSES; c++) tally_q[c] <= 4'd0;
					if (job.status == knn_pkg::ST_EMPTY) begin
						win_q <= '0; votes_q <= '0;
						state_q <= S_OUT;
					end else state_q <= S_MAC;
				end
				S_MAC: begin
					if (f_q < job_q.n_feat) f_q <= f_q + 1'b1;
					if (sq_v_s3) sum_q <= sum_n[39] ? '1 : sum_n[38:0];
					if (mac_done) begin
						pos_q <= filled_q;
						state_q <= S_INS;
					end
				end
				S_INS: begin
					if (pos_q != '0 && sum_q < bd_q[pos_q - 1'b1]) begin
						if (32'(pos_q) < knn_pkg::MAX_K) begin
							bd_q[pos_q] <= bd_q[pos_q - 1'b1];
							bl_q[pos_q] <= bl_q[pos_q - 1'b1];
						end
						pos_q <= pos_q - 1'b1;
					end else begin
						if (6'(pos_q) < job_q.k) begin
							bd_q[pos_q] <= sum_q;
							bl_q[pos_q] <= lab_q;
							if (6'(filled_q) < job_q.k) filled_q <= filled_q + 1'b1;
						end
						sum_q <= '0; f_q <= '0;
						if (11'(e_q) + 11'd1 >= job_q.n_entries) begin
							c_q <= '0; state_q <= S_VOTE;
						end else begin
							e_q <= e_q + 1'b1; state_q <= S_MAC;
						end
					end
				end
				S_VOTE: begin
					if (32'(c_q) < knn_pkg::MAX_K) begin
						if (KW'(c_q) < filled_q)
							tally_q[bl_q[c_q[KW-1:0]][CW-1:0]] <=
								tally_q[bl_q[c_q[KW-1:0]][CW-1:0]] + 4'd1;
						c_q <= c_q + 1'b1;
					end else begin
						votes_q <= best_cnt;
						win_q <= best_cls;
						state_q <= S_OUT;
					end
				end
				S_OUT: if (res_take) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[sv/knn_checker.sv]
// ------------------------------------------------------------------------
// knn_checker: port-level checks of the classifier.
// Watches the result side and the status codes.
// ------------------------------------------------------------------------
`include "knn_majority_classifier_unit_defines.svh"
module knn_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [2:0] predicted_class,
	input logic [3:0] winning_votes,
	input logic [1:0] status
);
	logic res_none;
	logic res_vote;
	logic zero_word;

	// A word for an empty store carries class zero and no votes.
	assign res_none = !empty && status == knn_pkg::ST_EMPTY;
	assign res_vote = !empty && status != knn_pkg::ST_EMPTY;
	assign zero_word = winning_votes == 4'd0 && predicted_class == 3'd0;

	`KNN_ASSERT_IMPL(a_stat, clk, arst_n, !empty, status <= knn_pkg::ST_CLAMPED)
	`KNN_ASSERT_IMPL(a_none, clk, arst_n, res_none, zero_word)
	`KNN_ASSERT_IMPL(a_votes, clk, arst_n, res_vote, winning_votes != 4'd0)
	`KNN_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(predicted_class))
endmodule

bind knn_majority_classifier_unit knn_checker u_chk (.clk, .arst_n, .empty, .pop,
	.predicted_class, .winning_votes, .status);

[tb/knn_tb_pkg.sv]
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// knn_tb_pkg: register indexes shared by the classifier testbench files.
// The stimulus writes these registers and the checker decodes them.
// ------------------------------------------------------------------------
package knn_tb_pkg;

	localparam logic [1:0] REG_NEIGHBORS = 2'd0;
	localparam logic [1:0] REG_ENTRIES   = 2'd1;
	localparam logic [1:0] REG_FEATURES  = 2'd2;

endpackage

[tb/knn_majority_classifier_unit_checker.sv]
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// knn_majority_classifier_unit_checker: result predictor and comparator.
// Mirrors the training store, query vector and registers from the accepted
// words, computes the expected vote for each final query word and compares
// every popped result against the oldest expected one.
// ------------------------------------------------------------------------
module knn_majority_classifier_unit_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [10:0]       wr_data,
	input  logic              push,
	input  logic              full,
	input  logic              action,
	input  logic [9:0]        entry_index,
	input  logic [4:0]        feature_index,
	input  logic signed [15:0] feature_value,
	input  logic [2:0]        class_label,
	input  logic              last_feature,
	input  logic              empty,
	input  logic              pop,
	input  logic [2:0]        predicted_class,
	input  logic [3:0]        winning_votes,
	input  logic [1:0]        status,
	output int                mismatches,
	output int                pending
);

	localparam int ENTRIES  = 1024;
	localparam int FEATURES = 32;
	localparam int KMAX     = 15;
	localparam int CLASSES  = 8;

	logic signed [15:0] train_feat [ENTRIES][FEATURES];
	logic [2:0]         train_lab [ENTRIES];
	logic signed [15:0] query_vec [FEATURES];
	logic [3:0]         cfg_k;
	logic [10:0]        cfg_entries;
	logic [5:0]         cfg_feat;
	knn_pkg::res_t      vote_q[$];
	int                 err_cnt;

	// Nearest-neighbor vote over the entries in use, as the block computes it.
	function automatic knn_pkg::res_t predict_vote();
		int unsigned n, nf, k, filled, pos, win, votes;
		longint unsigned best_dist [KMAX];
		logic [2:0] best_lab [KMAX];
		int unsigned tally [CLASSES];
		longint unsigned sq_sum;
		longint diff;
		knn_pkg::res_t r;
		n = (cfg_entries > ENTRIES) ? ENTRIES : cfg_entries;
		nf = (cfg_feat > FEATURES) ? FEATURES : cfg_feat;
		k = (cfg_k == 0) ? 1 : cfg_k;
		r.cls = '0;
		r.votes = '0;
		r.status = knn_pkg::ST_OK;
		if (n == 0) begin
			r.status = knn_pkg::ST_EMPTY;
			return r;
		end
		if (k > n) begin
			k = n;
			r.status = knn_pkg::ST_CLAMPED;
		end
		filled = 0;
		for (int e = 0; e < n; e++) begin
			sq_sum = 0;
			for (int f = 0; f < nf; f++) begin
				diff = longint'(query_vec[f]) - longint'(train_feat[e][f]);
				sq_sum += longint'(diff * diff);
			end
			// Strict compare keeps the lower entry ahead on equal distance.
			pos = filled;
			while (pos > 0 && sq_sum < best_dist[pos - 1])
				pos--;
			if (pos < k) begin
				if (filled < k)
					filled++;
				for (int i = filled - 1; i > pos; i--) begin
					best_dist[i] = best_dist[i - 1];
					best_lab[i] = best_lab[i - 1];
				end
				best_dist[pos] = sq_sum;
				best_lab[pos] = train_lab[e];
			end
		end
		for (int c = 0; c < CLASSES; c++)
			tally[c] = 0;
		for (int i = 0; i < filled; i++)
			tally[best_lab[i]]++;
		// Only a strictly larger count displaces, so the lowest class wins ties.
		win = 0;
		votes = 0;
		for (int c = 0; c < CLASSES; c++) begin
			if (tally[c] > votes) begin
				votes = tally[c];
				win = c;
			end
		end
		r.cls = win[2:0];
		r.votes = votes[3:0];
		return r;
	endfunction

	// Track registers and stores, queue expectations and check popped words.
	always @(posedge clk or negedge arst_n) begin
		knn_pkg::res_t exp_word;
		if (!arst_n) begin
			cfg_k = 4'd3;
			cfg_entries = 11'd0;
			cfg_feat = 6'd32;
			vote_q.delete();
			err_cnt = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					knn_tb_pkg::REG_NEIGHBORS: cfg_k = wr_data[3:0];
					knn_tb_pkg::REG_ENTRIES: cfg_entries = wr_data;
					knn_tb_pkg::REG_FEATURES: cfg_feat = wr_data[5:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (vote_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: unexpected result class %0d votes %0d status %0d",
							$realtime, predicted_class, winning_votes, status);
				end else begin
					exp_word = vote_q.pop_front();
					if (predicted_class !== exp_word.cls || winning_votes !== exp_word.votes ||
							status !== exp_word.status) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("%0t: result mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
								$realtime, exp_word.cls, exp_word.votes, exp_word.status,
								predicted_class, winning_votes, status);
					end
				end
			end
			if (push && !full) begin
				if (action == knn_pkg::ACT_LOAD) begin
					train_feat[entry_index][feature_index] = feature_value;
					train_lab[entry_index] = class_label;
				end else begin
					query_vec[feature_index] = feature_value;
					if (last_feature)
						vote_q.insert(vote_q.size(), predict_vote());
				end
			end
			mismatches <= err_cnt;
			pending <= vote_q.size();
		end
	end

endmodule

[tb/knn_majority_classifier_unit_tb.sv]
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// knn_majority_classifier_unit_tb: testbench top of the k-NN classifier.
// Loads training sets under a series of register settings, sends query
// vectors with random gaps and back pressure, and reports the verdict
// from the checker's mismatch and pending counts.
// ------------------------------------------------------------------------
module knn_majority_classifier_unit_tb;

	localparam int IDLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 3000;
	localparam int SETTLE = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [1:0] wr_index = '0;
	logic [10:0] wr_data = '0;
	logic push = 1'b0;
	logic full;
	logic action = knn_pkg::ACT_LOAD;
	logic [9:0] entry_index = '0;
	logic [4:0] feature_index = '0;
	logic signed [15:0] feature_value = '0;
	logic [2:0] class_label = '0;
	logic last_feature = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [2:0] predicted_class;
	logic [3:0] winning_votes;
	logic [1:0] status;
	int mismatches;
	int pending;
	int idle_cycles = 0;
	bit hold_req = 1'b0;
	bit no_gaps = 1'b0;

	knn_majority_classifier_unit i_dut (.*);

	knn_majority_classifier_unit_checker i_checker (.*);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on cycles with no accepted word, register write or popped result.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL knn_majority_classifier_unit");
			$finish;
		end
	end

	// Gap length: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Feature value: extremes, a narrow band that forces ties, or anything.
	function automatic logic signed [15:0] pick_value(int mode);
		int r;
		r = $urandom_range(0, 2);
		if (mode == 0)
			return (r == 0) ? 16'sh7FFF : (r == 1) ? 16'sh8000 : 16'sh0000;
		if (mode == 1)
			return 16'(signed'($urandom_range(0, 4)) - 2);
		return 16'($urandom);
	endfunction

	// Receiver: random pop gaps, plus one long hold-off on request.
	initial begin
		int idle_left;
		idle_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_left > 0) begin
				pop <= 1'b0;
				idle_left--;
			end else begin
				pop <= 1'b1;
				idle_left = pick_gap();
			end
		end
	end

	// Send one word and wait until it is accepted.
	task automatic send_word(logic act, int entry, int feat, logic signed [15:0] val,
			int label, logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		action <= act;
		entry_index <= 10'(entry);
		feature_index <= 5'(feat);
		feature_value <= val;
		class_label <= 3'(label);
		last_feature <= last;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// Let every expected result drain, then the pipeline settle.
	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= 11'(value);
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// One setting: program registers, load every entry in use, run queries.
	task automatic run_setting(int k, int entries_reg, int feat_reg, int queries, int mode);
		int ne, nf, extra;
		ne = (entries_reg > 1024) ? 1024 : entries_reg;
		nf = (feat_reg > 32) ? 32 : feat_reg;
		wait_idle();
		write_reg(knn_tb_pkg::REG_NEIGHBORS, k);
		write_reg(knn_tb_pkg::REG_ENTRIES, entries_reg);
		write_reg(knn_tb_pkg::REG_FEATURES, feat_reg);
		// A load always touches feature 0 so the label is written.
		for (int e = 0; e < ne; e++)
			for (int f = 0; f < ((nf == 0) ? 1 : nf); f++)
				send_word(knn_pkg::ACT_LOAD, e, f, pick_value(mode), $urandom_range(0, 7),
					1'($urandom_range(0, 1)));
		for (int q = 0; q < queries; q++) begin
			if (q == 0) begin
				for (int f = 0; f < nf - 1; f++)
					send_word(knn_pkg::ACT_QUERY, $urandom_range(0, 1023), f,
						pick_value(mode), $urandom_range(0, 7), 1'b0);
				send_word(knn_pkg::ACT_QUERY, $urandom_range(0, 1023),
					(nf == 0) ? $urandom_range(0, 31) : nf - 1, pick_value(mode),
					$urandom_range(0, 7), 1'b1);
			end else begin
				// Rewrite an entry in use now and then between queries.
				if (ne > 0 && $urandom_range(0, 3) == 0)
					send_word(knn_pkg::ACT_LOAD, $urandom_range(0, ne - 1),
						(nf == 0) ? 0 : $urandom_range(0, nf - 1), pick_value(mode),
						$urandom_range(0, 7), 1'b0);
				extra = $urandom_range(0, 3);
				for (int i = 0; i < extra; i++)
					send_word(knn_pkg::ACT_QUERY, $urandom_range(0, 1023),
						$urandom_range(0, 31), pick_value(mode), $urandom_range(0, 7), 1'b0);
				send_word(knn_pkg::ACT_QUERY, $urandom_range(0, 1023), $urandom_range(0, 31),
					pick_value(mode), $urandom_range(0, 7), 1'b1);
			end
		end
	endtask

	// Stimulus and verdict.
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: no entries in use.
		send_word(knn_pkg::ACT_QUERY, 0, 0, 16'sh0000, 0, 1'b1);

		// Directed settings: extremes, clamping, zero k, zero features, no entries.
		run_setting(1, 1, 1, 2, 0);
		run_setting(15, 4, 2, 2, 0);
		run_setting(0, 3, 4, 2, 0);
		run_setting(3, 5, 0, 1, 2);
		run_setting(5, 0, 4, 1, 2);

		// Random settings, half of them in the narrow band for ties.
		for (int p = 0; p < 4; p++) begin
			no_gaps = (p == 1);
			run_setting($urandom_range(1, 15), $urandom_range(1, 4), $urandom_range(1, 3),
				$urandom_range(2, 3), (p % 2 == 0) ? 1 : 2);
		end
		no_gaps = 1'b0;

		// Back pressure: the receiver holds off while final queries keep coming.
		run_setting(1, 2, 1, 1, 2);
		hold_req = 1'b1;
		for (int i = 0; i < 8; i++)
			send_word(knn_pkg::ACT_QUERY, 0, 0, pick_value(2), 0, 1'b1);

		wait_idle();
		if (mismatches == 0 && pending == 0)
			$display("PASS knn_majority_classifier_unit");
		else
			$display("FAIL knn_majority_classifier_unit");
		$finish;
	end

endmodule
